// ----- sv/assert_macros.svh -----
// Assertion macros shared by the rotation displacement RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while rst is high.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off while rst is high.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/rad_pkg.sv -----
// Shared types, register codes, width helpers and saturating arithmetic.
`default_nettype none

package rad_pkg;

  localparam int UNIT_W    = 16;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_DIR_X    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_DIR_Y    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_DIR_Z    = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_COS      = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_SIN      = 3'd7;

  localparam logic signed [127:0] WIDE_MAX = 128'sh7fff_ffff_ffff_ffff;
  localparam logic signed [127:0] WIDE_MIN = -WIDE_MAX;

  typedef struct packed {
    logic signed [UNIT_W-1:0] dir_x;
    logic signed [UNIT_W-1:0] dir_y;
    logic signed [UNIT_W-1:0] dir_z;
    logic signed [UNIT_W-1:0] cos_a;
    logic signed [UNIT_W-1:0] sin_a;
  } unit_cfg_t;

  function automatic int imin(input int a, input int b);
    return (a < b) ? a : b;
  endfunction

  function automatic int imax(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  // APB data width and address stride follow the widest register
  function automatic int apb_data_w(input int cw);
    return (cw > 32) ? 64 : 32;
  endfunction

  function automatic int apb_addr_lsb(input int cw);
    return (cw > 32) ? 3 : 2;
  endfunction

  // datapath widths, each just wide enough for its value range
  function automatic int p_w(input int cw);
    return cw + 1;
  endfunction

  function automatic int prod_w(input int cw);
    return UNIT_W + cw + 1;
  endfunction

  function automatic int m_w(input int cw);
    return imin(prod_w(cw), 64);
  endfunction

  function automatic int dot_w(input int cw, input int f);
    return imin(prod_w(cw) + 3, 64) - f;
  endfunction

  function automatic int o_w(input int f);
    return imax(f + 2, UNIT_W + 1);
  endfunction

  function automatic int b_w(input int f);
    return o_w(f) + UNIT_W + 1 - f;
  endfunction

  function automatic int t1_w(input int cw, input int f);
    return imin(o_w(f) + p_w(cw), 64);
  endfunction

  function automatic int t2_w(input int cw, input int f);
    return imin(b_w(f) + dot_w(cw, f), 64);
  endfunction

  function automatic int t3_w(input int cw, input int f);
    return imin(UNIT_W + dot_w(cw, f), 64);
  endfunction

  function automatic int rel_w(input int cw, input int f);
    return imin(imax(t1_w(cw, f), imax(t2_w(cw, f), t3_w(cw, f))) + 3, 64) - f;
  endfunction

  function automatic int q_w(input int cw, input int f);
    return imin(rel_w(cw, f) + UNIT_W, 64);
  endfunction

  // clamp to +-(2^63 - 1)
  function automatic logic signed [63:0] sat64(input logic signed [127:0] v);
    logic signed [63:0] r;
    if (v > WIDE_MAX) begin
      r = WIDE_MAX[63:0];
    end else if (v < WIDE_MIN) begin
      r = WIDE_MIN[63:0];
    end else begin
      r = v[63:0];
    end
    return r;
  endfunction

  // drop frac bits, round half up, saturating add of the half
  function automatic logic signed [63:0] rnd(input logic signed [63:0] v, input int frac);
    logic signed [127:0] half;
    logic signed [63:0]  t;
    half = 128'sd1 <<< (frac - 1);
    t    = sat64(128'(v) + half);
    return t >>> frac;
  endfunction

endpackage

`default_nettype wire

// ----- sv/rad_cfg.sv -----
// APB register bank: axis origin, axis direction, cosine and sine.
`default_nettype none

`include "assert_macros.svh"

module rad_cfg #(
  parameter int COORD_WIDTH    = 32,
  parameter int UNIT_FRAC_BITS = 14,
  localparam int DATA_W   = rad_pkg::apb_data_w(COORD_WIDTH),
  localparam int ADDR_LSB = rad_pkg::apb_addr_lsb(COORD_WIDTH),
  localparam int ADDR_W   = ADDR_LSB + rad_pkg::REG_IDX_W
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ADDR_W-1:0]             paddr,
  input  logic [DATA_W-1:0]             pwdata,
  output logic [DATA_W-1:0]             prdata,
  output logic                          pready,
  output logic signed [COORD_WIDTH-1:0] origin_x,
  output logic signed [COORD_WIDTH-1:0] origin_y,
  output logic signed [COORD_WIDTH-1:0] origin_z,
  output rad_pkg::unit_cfg_t            cfg
);

  localparam int UW = rad_pkg::UNIT_W;
  localparam logic signed [UW-1:0] ONE_U = UW'(1 << UNIT_FRAC_BITS);

  logic                          wr;
  logic [rad_pkg::REG_IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign idx    = paddr[ADDR_W-1:ADDR_LSB];

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x  <= '0;
      origin_y  <= '0;
      origin_z  <= '0;
      cfg.dir_x <= '0;
      cfg.dir_y <= '0;
      cfg.dir_z <= ONE_U;
      cfg.cos_a <= ONE_U;
      cfg.sin_a <= '0;
    end else if (wr) begin
      case (idx)
        rad_pkg::REG_ORIGIN_X: origin_x  <= pwdata[COORD_WIDTH-1:0];
        rad_pkg::REG_ORIGIN_Y: origin_y  <= pwdata[COORD_WIDTH-1:0];
        rad_pkg::REG_ORIGIN_Z: origin_z  <= pwdata[COORD_WIDTH-1:0];
        rad_pkg::REG_DIR_X:    cfg.dir_x <= pwdata[UW-1:0];
        rad_pkg::REG_DIR_Y:    cfg.dir_y <= pwdata[UW-1:0];
        rad_pkg::REG_DIR_Z:    cfg.dir_z <= pwdata[UW-1:0];
        rad_pkg::REG_COS:      cfg.cos_a <= pwdata[UW-1:0];
        rad_pkg::REG_SIN:      cfg.sin_a <= pwdata[UW-1:0];
        default: ;
      endcase
    end
  end

  // readback, sign-extended to the bus
  always_comb begin
    case (idx)
      rad_pkg::REG_ORIGIN_X: prdata = DATA_W'(origin_x);
      rad_pkg::REG_ORIGIN_Y: prdata = DATA_W'(origin_y);
      rad_pkg::REG_ORIGIN_Z: prdata = DATA_W'(origin_z);
      rad_pkg::REG_DIR_X:    prdata = DATA_W'(cfg.dir_x);
      rad_pkg::REG_DIR_Y:    prdata = DATA_W'(cfg.dir_y);
      rad_pkg::REG_DIR_Z:    prdata = DATA_W'(cfg.dir_z);
      rad_pkg::REG_COS:      prdata = DATA_W'(cfg.cos_a);
      rad_pkg::REG_SIN:      prdata = DATA_W'(cfg.sin_a);
      default:               prdata = '0;
    endcase
  end

  `ASSERT_NEXT(a_cos_readback, wr && (idx == rad_pkg::REG_COS), prdata[UW-1:0] == $past(pwdata[UW-1:0]) || idx != rad_pkg::REG_COS, "cosine readback differs from last write")

endmodule

`default_nettype wire

// ----- sv/rad_geom.sv -----
// Front stages: shift to axis frame, direction products, dot and cross.
`default_nettype none

module rad_geom #(
  parameter int COORD_WIDTH    = 32,
  parameter int UNIT_FRAC_BITS = 14,
  localparam int DOTW = rad_pkg::dot_w(COORD_WIDTH, UNIT_FRAC_BITS),
  localparam int T1W  = rad_pkg::t1_w(COORD_WIDTH, UNIT_FRAC_BITS)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic signed [COORD_WIDTH-1:0] coord_x,
  input  logic signed [COORD_WIDTH-1:0] coord_y,
  input  logic signed [COORD_WIDTH-1:0] coord_z,
  input  logic signed [15:0]            weight,
  input  logic signed [COORD_WIDTH-1:0] origin_x,
  input  logic signed [COORD_WIDTH-1:0] origin_y,
  input  logic signed [COORD_WIDTH-1:0] origin_z,
  input  rad_pkg::unit_cfg_t            cfg,
  output logic                          v3,
  output logic signed [DOTW-1:0]        dot3,
  output logic signed [DOTW-1:0]        crs3 [3],
  output logic signed [T1W-1:0]         t1_3 [3],
  output logic signed [15:0]            w3
);

  localparam int PW    = rad_pkg::p_w(COORD_WIDTH);
  localparam int PRODW = rad_pkg::prod_w(COORD_WIDTH);
  localparam int MW    = rad_pkg::m_w(COORD_WIDTH);
  localparam int OW    = rad_pkg::o_w(UNIT_FRAC_BITS);
  localparam int CPW   = OW + PW;
  localparam logic signed [OW-1:0] ONE_W = OW'(64'sd1 <<< UNIT_FRAC_BITS);

  // stage 1: vertex relative to origin
  logic                 v1;
  logic signed [PW-1:0] p1 [3];
  logic signed [15:0]   w1;

  // stage 2: products
  logic                    v2;
  logic signed [MW-1:0]    m2 [3][3];
  logic signed [T1W-1:0]   t1_2 [3];
  logic signed [15:0]      w2;

  logic signed [15:0]      d [3];
  logic signed [OW-1:0]    cm1;
  logic signed [PRODW-1:0] prod [3][3];
  logic signed [CPW-1:0]   cprod [3];
  logic signed [MW-1:0]    m_next [3][3];
  logic signed [T1W-1:0]   t1_next [3];

  logic signed [DOTW-1:0]  dot_next;
  logic signed [DOTW-1:0]  crs_next [3];

  assign d[0] = cfg.dir_x;
  assign d[1] = cfg.dir_y;
  assign d[2] = cfg.dir_z;
  assign cm1  = OW'(cfg.cos_a) - ONE_W;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1[0] <= PW'(coord_x) - PW'(origin_x);
      p1[1] <= PW'(coord_y) - PW'(origin_y);
      p1[2] <= PW'(coord_z) - PW'(origin_z);
      w1    <= weight;
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      for (int k = 0; k < 3; k++) begin
        prod[j][k]   = PRODW'(d[j]) * PRODW'(p1[k]);
        m_next[j][k] = MW'(rad_pkg::sat64(128'(prod[j][k])));
      end
      cprod[j]   = CPW'(cm1) * CPW'(p1[j]);
      t1_next[j] = T1W'(rad_pkg::sat64(128'(cprod[j])));
    end
  end

  always_ff @(posedge clk) begin
    if (v1) begin
      m2   <= m_next;
      t1_2 <= t1_next;
      w2   <= w1;
    end
  end

  // stage 3: d.p and d x p, each sum saturating step by step
  always_comb begin
    dot_next = DOTW'(rad_pkg::rnd(rad_pkg::sat64(
                 128'(rad_pkg::sat64(128'(m2[0][0]) + 128'(m2[1][1]))) + 128'(m2[2][2])),
                 UNIT_FRAC_BITS));
    crs_next[0] = DOTW'(rad_pkg::rnd(rad_pkg::sat64(128'(m2[1][2]) - 128'(m2[2][1])),
                  UNIT_FRAC_BITS));
    crs_next[1] = DOTW'(rad_pkg::rnd(rad_pkg::sat64(128'(m2[2][0]) - 128'(m2[0][2])),
                  UNIT_FRAC_BITS));
    crs_next[2] = DOTW'(rad_pkg::rnd(rad_pkg::sat64(128'(m2[0][1]) - 128'(m2[1][0])),
                  UNIT_FRAC_BITS));
  end

  always_ff @(posedge clk) begin
    if (v2) begin
      dot3 <= dot_next;
      crs3 <= crs_next;
      t1_3 <= t1_2;
      w3   <= w2;
    end
  end

endmodule

`default_nettype wire

// ----- sv/rad_blend.sv -----
// Back stages: Rodrigues blend, weighting, rounding and output clamp.
`default_nettype none

module rad_blend #(
  parameter int COORD_WIDTH    = 32,
  parameter int UNIT_FRAC_BITS = 14,
  localparam int DOTW = rad_pkg::dot_w(COORD_WIDTH, UNIT_FRAC_BITS),
  localparam int T1W  = rad_pkg::t1_w(COORD_WIDTH, UNIT_FRAC_BITS)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  rad_pkg::unit_cfg_t            cfg,
  input  logic                          v3,
  input  logic signed [DOTW-1:0]        dot3,
  input  logic signed [DOTW-1:0]        crs3 [3],
  input  logic signed [T1W-1:0]         t1_3 [3],
  input  logic signed [15:0]            w3,
  output logic                          done,
  output logic signed [COORD_WIDTH-1:0] disp [3]
);

  localparam int OW   = rad_pkg::o_w(UNIT_FRAC_BITS);
  localparam int BW   = rad_pkg::b_w(UNIT_FRAC_BITS);
  localparam int T2W  = rad_pkg::t2_w(COORD_WIDTH, UNIT_FRAC_BITS);
  localparam int T3W  = rad_pkg::t3_w(COORD_WIDTH, UNIT_FRAC_BITS);
  localparam int RELW = rad_pkg::rel_w(COORD_WIDTH, UNIT_FRAC_BITS);
  localparam int QW   = rad_pkg::q_w(COORD_WIDTH, UNIT_FRAC_BITS);
  localparam int OBW  = OW + 16;
  localparam int P2W  = BW + DOTW;
  localparam int P3W  = 16 + DOTW;
  localparam int PQW  = RELW + 16;
  localparam logic signed [OW-1:0] ONE_W   = OW'(64'sd1 <<< UNIT_FRAC_BITS);
  localparam logic signed [63:0]   OUT_MAX = (64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1;
  localparam logic signed [63:0]   OUT_MIN = -OUT_MAX - 64'sd1;

  logic signed [15:0]     d [3];
  logic signed [OW-1:0]   omc;
  logic signed [OBW-1:0]  ob [3];
  logic signed [BW-1:0]   b [3];

  logic                   v4, v5, v6;
  logic signed [T1W-1:0]  t1_4 [3];
  logic signed [T2W-1:0]  t2_4 [3];
  logic signed [T3W-1:0]  t3_4 [3];
  logic signed [15:0]     w4, w5;
  logic signed [RELW-1:0] rel5 [3];
  logic signed [QW-1:0]   q6 [3];

  logic signed [P2W-1:0]  p2 [3];
  logic signed [P3W-1:0]  p3 [3];
  logic signed [PQW-1:0]  pq [3];
  logic signed [RELW-1:0] rel_next [3];
  logic signed [63:0]     fin [3];

  assign d[0] = cfg.dir_x;
  assign d[1] = cfg.dir_y;
  assign d[2] = cfg.dir_z;
  assign omc  = ONE_W - OW'(cfg.cos_a);

  // (1 - cos) * d, held from configuration, rounded and registered for stage 4
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ob[i] = OBW'(omc) * OBW'(d[i]);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      b[i] <= BW'(rad_pkg::rnd(rad_pkg::sat64(128'(ob[i])), UNIT_FRAC_BITS));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4   <= 1'b0;
      v5   <= 1'b0;
      v6   <= 1'b0;
      done <= 1'b0;
    end else begin
      v4   <= v3;
      v5   <= v4;
      v6   <= v5;
      done <= v6;
    end
  end

  // stage 4: b * dot and sin * cross
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p2[i] = P2W'(b[i]) * P2W'(dot3);
      p3[i] = P3W'(cfg.sin_a) * P3W'(crs3[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (v3) begin
      for (int i = 0; i < 3; i++) begin
        t1_4[i] <= t1_3[i];
        t2_4[i] <= T2W'(rad_pkg::sat64(128'(p2[i])));
        t3_4[i] <= T3W'(rad_pkg::sat64(128'(p3[i])));
      end
      w4 <= w3;
    end
  end

  // stage 5: rotated offset, saturating at each add
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rel_next[i] = RELW'(rad_pkg::rnd(rad_pkg::sat64(
                      128'(rad_pkg::sat64(128'(t1_4[i]) + 128'(t2_4[i]))) + 128'(t3_4[i])),
                      UNIT_FRAC_BITS));
    end
  end

  always_ff @(posedge clk) begin
    if (v4) begin
      rel5 <= rel_next;
      w5   <= w4;
    end
  end

  // stage 6: weighting
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pq[i] = PQW'(rel5[i]) * PQW'(w5);
    end
  end

  always_ff @(posedge clk) begin
    if (v5) begin
      for (int i = 0; i < 3; i++) begin
        q6[i] <= QW'(rad_pkg::sat64(128'(pq[i])));
      end
    end
  end

  // stage 7: final rounding and clamp to the coordinate range
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fin[i] = rad_pkg::rnd(64'(q6[i]), UNIT_FRAC_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (v6) begin
      for (int i = 0; i < 3; i++) begin
        if (fin[i] > OUT_MAX) begin
          disp[i] <= OUT_MAX[COORD_WIDTH-1:0];
        end else if (fin[i] < OUT_MIN) begin
          disp[i] <= OUT_MIN[COORD_WIDTH-1:0];
        end else begin
          disp[i] <= fin[i][COORD_WIDTH-1:0];
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/axis_rotation_displacement.sv -----
// Top level: weighted displacement of a vertex rotated about a configured axis.
//
//  channel   handshake                      payload
//  --------  -----------------------------  ----------------------------------
//  vertex    start in, busy out             coord_x, coord_y, coord_z, weight
//  result    done out (one-cycle strobe)    disp_x, disp_y, disp_z
//  config    APB psel/penable/pwrite/pready paddr, pwdata, prdata
//
// A vertex request is taken at every edge with start high; busy is held low, so
// one vertex per clock is sustained. Each result passes through seven register
// stages in order: origin shift, direction products, dot/cross rounding, blend
// products, blend sum, weighting, round and clamp. rst (synchronous, active
// high) clears the stage valid bits and loads the identity rotation about +z
// with zero origin. The receiver takes every result as it comes; nothing in
// the pipe ever waits.
`default_nettype none

`include "assert_macros.svh"

module axis_rotation_displacement #(
  parameter int COORD_WIDTH    = 32,
  parameter int UNIT_FRAC_BITS = 14,
  localparam int DATA_W   = rad_pkg::apb_data_w(COORD_WIDTH),
  localparam int ADDR_LSB = rad_pkg::apb_addr_lsb(COORD_WIDTH),
  localparam int ADDR_W   = ADDR_LSB + rad_pkg::REG_IDX_W
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ADDR_W-1:0]             paddr,
  input  logic [DATA_W-1:0]             pwdata,
  output logic [DATA_W-1:0]             prdata,
  output logic                          pready,
  // vertex requests
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] coord_x,
  input  logic signed [COORD_WIDTH-1:0] coord_y,
  input  logic signed [COORD_WIDTH-1:0] coord_z,
  input  logic signed [15:0]            weight,
  // results
  output logic                          done,
  output logic signed [COORD_WIDTH-1:0] disp_x,
  output logic signed [COORD_WIDTH-1:0] disp_y,
  output logic signed [COORD_WIDTH-1:0] disp_z
);

  localparam int DOTW = rad_pkg::dot_w(COORD_WIDTH, UNIT_FRAC_BITS);
  localparam int T1W  = rad_pkg::t1_w(COORD_WIDTH, UNIT_FRAC_BITS);

  logic                          accept;
  logic signed [COORD_WIDTH-1:0] origin_x, origin_y, origin_z;
  rad_pkg::unit_cfg_t            cfg;

  // hand-off between the front and back halves of the pipe
  logic                          v3;
  logic signed [DOTW-1:0]        dot3;
  logic signed [DOTW-1:0]        crs3 [3];
  logic signed [T1W-1:0]         t1_3 [3];
  logic signed [15:0]            w3;
  logic signed [COORD_WIDTH-1:0] disp [3];

  // fully pipelined, never back-pressures the sender
  assign busy   = 1'b0;
  assign accept = start && !busy;

  rad_cfg #(
    .COORD_WIDTH   (COORD_WIDTH),
    .UNIT_FRAC_BITS(UNIT_FRAC_BITS)
  ) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .origin_x(origin_x),
    .origin_y(origin_y),
    .origin_z(origin_z),
    .cfg     (cfg)
  );

  // stages 1..3: p = coord - origin, d_j*p_k and (cos-1)*p, then d.p and d x p
  rad_geom #(
    .COORD_WIDTH   (COORD_WIDTH),
    .UNIT_FRAC_BITS(UNIT_FRAC_BITS)
  ) u_geom (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .coord_x (coord_x),
    .coord_y (coord_y),
    .coord_z (coord_z),
    .weight  (weight),
    .origin_x(origin_x),
    .origin_y(origin_y),
    .origin_z(origin_z),
    .cfg     (cfg),
    .v3      (v3),
    .dot3    (dot3),
    .crs3    (crs3),
    .t1_3    (t1_3),
    .w3      (w3)
  );

  // stages 4..7: blend with (1-cos)d and sin, weight, round, clamp
  rad_blend #(
    .COORD_WIDTH   (COORD_WIDTH),
    .UNIT_FRAC_BITS(UNIT_FRAC_BITS)
  ) u_blend (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .v3  (v3),
    .dot3(dot3),
    .crs3(crs3),
    .t1_3(t1_3),
    .w3  (w3),
    .done(done),
    .disp(disp)
  );

  assign disp_x = disp[0];
  assign disp_y = disp[1];
  assign disp_z = disp[2];

  // every request yields a result, and nothing else does
  `ASSERT_NEXT(a_req_to_result, start && !busy, ##6 done, "request did not yield a result after seven cycles")
  `ASSERT_IMPL(a_no_stray_result, done, $past(start && !busy, 7), "result without a matching request")

endmodule

`default_nettype wire

// ----- tb/sv/disp_check_pkg.sv -----
// Displacement predictor and in-order result scoreboard for the rotation block.
`timescale 1ns / 100ps

package disp_check_pkg;

  localparam int CW   = 32;
  localparam int FRAC = 14;

  typedef logic signed [127:0] wide_t;
  typedef logic signed [63:0]  acc_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic signed [15:0]   w;
  } vertex_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } disp_t;

  localparam wide_t ACC_MAX_W = 128'sh7fff_ffff_ffff_ffff;
  localparam acc_t  ACC_MAX   = 64'sh7fff_ffff_ffff_ffff;
  localparam wide_t HALF_LSB  = 128'sd1 <<< (FRAC - 1);
  localparam acc_t  UNIT_ONE  = 64'sd1 <<< FRAC;
  localparam acc_t  OUT_MAX   = (64'sd1 <<< (CW - 1)) - 64'sd1;
  localparam acc_t  OUT_MIN   = -OUT_MAX - 64'sd1;

  class disp_scoreboard;
    acc_t  org [3];
    acc_t  dir [3];
    acc_t  cos_q;
    acc_t  sin_q;
    disp_t expected_disp [$];
    int    fails = 0;

    // identity rotation about +z, origin at zero
    function void load_reset();
      org   = '{64'sd0, 64'sd0, 64'sd0};
      dir   = '{64'sd0, 64'sd0, UNIT_ONE};
      cos_q = UNIT_ONE;
      sin_q = 64'sd0;
    endfunction

    function void set_reg(logic [rad_pkg::REG_IDX_W-1:0] idx, logic [31:0] val);
      logic signed [CW-1:0] v_coord;
      logic signed [15:0]   v_unit;
      v_coord = val;
      v_unit  = val[15:0];
      case (idx)
        rad_pkg::REG_ORIGIN_X: org[0] = v_coord;
        rad_pkg::REG_ORIGIN_Y: org[1] = v_coord;
        rad_pkg::REG_ORIGIN_Z: org[2] = v_coord;
        rad_pkg::REG_DIR_X:    dir[0] = v_unit;
        rad_pkg::REG_DIR_Y:    dir[1] = v_unit;
        rad_pkg::REG_DIR_Z:    dir[2] = v_unit;
        rad_pkg::REG_COS:      cos_q  = v_unit;
        rad_pkg::REG_SIN:      sin_q  = v_unit;
        default: ;
      endcase
    endfunction

    // symmetric clamp to +-(2^63 - 1)
    function acc_t clip(wide_t v);
      if (v > ACC_MAX_W) return ACC_MAX;
      if (v < -ACC_MAX_W) return -ACC_MAX;
      return v[63:0];
    endfunction

    function acc_t add(wide_t a, wide_t b);
      return clip(a + b);
    endfunction

    function acc_t mul(wide_t a, wide_t b);
      return clip(a * b);
    endfunction

    // drop FRAC bits, ties towards +inf
    function acc_t half_up(wide_t v);
      acc_t t;
      t = clip(v + HALF_LSB);
      return t >>> FRAC;
    endfunction

    function logic signed [CW-1:0] clamp_out(acc_t v);
      if (v > OUT_MAX) return OUT_MAX[CW-1:0];
      if (v < OUT_MIN) return OUT_MIN[CW-1:0];
      return v[CW-1:0];
    endfunction

    function disp_t rotate_disp(vertex_t v);
      acc_t  c [3];
      acc_t  p [3];
      acc_t  crs [3];
      logic signed [CW-1:0] res [3];
      acc_t  dot_q, cm1, omc, wt, b, acc, rel;
      c[0] = v.x;
      c[1] = v.y;
      c[2] = v.z;
      wt   = v.w;
      for (int i = 0; i < 3; i++) p[i] = add(c[i], -org[i]);
      dot_q = half_up(add(add(mul(dir[0], p[0]), mul(dir[1], p[1])), mul(dir[2], p[2])));
      crs[0] = half_up(add(mul(dir[1], p[2]), -mul(dir[2], p[1])));
      crs[1] = half_up(add(mul(dir[2], p[0]), -mul(dir[0], p[2])));
      crs[2] = half_up(add(mul(dir[0], p[1]), -mul(dir[1], p[0])));
      cm1 = cos_q - UNIT_ONE;
      omc = UNIT_ONE - cos_q;
      for (int i = 0; i < 3; i++) begin
        b      = half_up(mul(omc, dir[i]));
        acc    = mul(cm1, p[i]);
        acc    = add(acc, mul(b, dot_q));
        acc    = add(acc, mul(sin_q, crs[i]));
        rel    = half_up(acc);
        res[i] = clamp_out(half_up(mul(rel, wt)));
      end
      return '{x: res[0], y: res[1], z: res[2]};
    endfunction

    function void note_vertex(vertex_t v);
      expected_disp.push_back(rotate_disp(v));
    endfunction

    function void cmp_field(string name, logic signed [CW-1:0] want,
                            logic signed [CW-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        fails++;
      end
    endfunction

    function void check_disp(disp_t got);
      disp_t want;
      if (expected_disp.size() == 0) begin
        $error("result with no request outstanding: %0d %0d %0d", got.x, got.y, got.z);
        fails++;
        return;
      end
      want = expected_disp.pop_front();
      cmp_field("disp_x", want.x, got.x);
      cmp_field("disp_y", want.y, got.y);
      cmp_field("disp_z", want.z, got.z);
    endfunction
  endclass

endpackage

// ----- tb/sv/tb_top.sv -----
// Top-level testbench: rotation displacement block driven by requests and APB writes.
`timescale 1ns / 100ps

module tb_top;

  typedef disp_check_pkg::vertex_t vertex_t;
  typedef disp_check_pkg::disp_t   disp_t;

  // seven register stages between request and result
  localparam int LATENCY = 7;

  logic                 clk;
  logic                 rst;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [4:0]           paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;
  logic                 start;
  logic                 busy;
  logic signed [31:0]   coord_x;
  logic signed [31:0]   coord_y;
  logic signed [31:0]   coord_z;
  logic signed [15:0]   weight;
  logic                 done;
  logic signed [31:0]   disp_x;
  logic signed [31:0]   disp_y;
  logic signed [31:0]   disp_z;

  disp_check_pkg::disp_scoreboard sb;

  axis_rotation_displacement u_dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .start   (start),
    .busy    (busy),
    .coord_x (coord_x),
    .coord_y (coord_y),
    .coord_z (coord_z),
    .weight  (weight),
    .done    (done),
    .disp_x  (disp_x),
    .disp_y  (disp_y),
    .disp_z  (disp_z)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

  // Monitor: everything is sampled on the rising edge, all stimulus moves on
  // the falling edge, so there is no ordering hazard within a time step.
  // A request is noted when it is taken; a done strobe is checked against the
  // oldest prediction. done is compared with !== so an X strobe is caught.
  always @(posedge clk) begin
    if (!rst && start && !busy) begin
      sb.note_vertex(vertex_t'{coord_x, coord_y, coord_z, weight});
    end
    if (!rst && done !== 1'b0) begin
      sb.check_disp(disp_t'{disp_x, disp_y, disp_z});
    end
  end

  // Gap lengths: mostly none or short, the odd long pause.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Random vertex. Full-range coordinates mostly saturate, so the bulk are
  // narrowed by an arithmetic shift to keep results in range while still
  // exercising both signs.
  function automatic vertex_t rand_vertex();
    vertex_t v;
    int      sh;
    int      wk;
    sh  = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(8, 20);
    v.x = $signed($urandom) >>> sh;
    v.y = $signed($urandom) >>> sh;
    v.z = $signed($urandom) >>> sh;
    wk  = $urandom_range(0, 9);
    if (wk < 7) v.w = 16'($urandom);
    else if (wk == 7) v.w = 16'sd16384;
    else if (wk == 8) v.w = -16'sd16384;
    else v.w = 16'sd0;
    return v;
  endfunction

  task automatic idle(input int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // Present one request and hold it until the block takes it. start stays
  // high on return so back-to-back requests see no bubble.
  task automatic send_vertex(input vertex_t v);
    @(negedge clk);
    start   <= 1'b1;
    coord_x <= v.x;
    coord_y <= v.y;
    coord_z <= v.z;
    weight  <= v.w;
    do @(posedge clk); while (busy);
  endtask

  // Drop start and wait for the pipe to empty, bounded so a lost result
  // shows up as a leftover rather than a hang.
  task automatic drain();
    int waited;
    waited = 0;
    @(negedge clk);
    start <= 1'b0;
    while (sb.expected_disp.size() != 0 && waited < 1000) begin
      @(posedge clk);
      waited++;
    end
    repeat (LATENCY + 3) @(posedge clk);
  endtask

  // APB write: setup then access phase; committed on the edge with pready.
  task automatic apb_write(input logic [rad_pkg::REG_IDX_W-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, val);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Rewrite the whole axis set; only ever called with the pipe empty.
  task automatic load_axis(input logic [31:0] ox, input logic [31:0] oy, input logic [31:0] oz,
                           input logic [15:0] dx, input logic [15:0] dy, input logic [15:0] dz,
                           input logic [15:0] c, input logic [15:0] s);
    drain();
    apb_write(rad_pkg::REG_ORIGIN_X, ox);
    apb_write(rad_pkg::REG_ORIGIN_Y, oy);
    apb_write(rad_pkg::REG_ORIGIN_Z, oz);
    apb_write(rad_pkg::REG_DIR_X, {{16{dx[15]}}, dx});
    apb_write(rad_pkg::REG_DIR_Y, {{16{dy[15]}}, dy});
    apb_write(rad_pkg::REG_DIR_Z, {{16{dz[15]}}, dz});
    apb_write(rad_pkg::REG_COS,   {{16{c[15]}}, c});
    apb_write(rad_pkg::REG_SIN,   {{16{s[15]}}, s});
  endtask

  // Random axis set: mostly a genuine unit axis and angle, sometimes raw
  // bit patterns (non-unit axis, inconsistent cos/sin, full-range origin).
  task automatic random_axis();
    logic [31:0] o [3];
    logic [15:0] u [5];
    real         ang, ax, ay, az, nrm;
    int          kind;
    kind = $urandom_range(0, 7);
    for (int i = 0; i < 3; i++) begin
      if (kind == 7) o[i] = $urandom;
      else o[i] = $signed($urandom) >>> $urandom_range(6, 16);
    end
    if (kind >= 6) begin
      for (int i = 0; i < 5; i++) u[i] = 16'($urandom);
    end else begin
      ang = real'($urandom_range(0, 3599)) * 3.14159265358979 / 1800.0;
      ax  = (real'($urandom_range(0, 2000)) - 1000.0) / 1000.0;
      ay  = (real'($urandom_range(0, 2000)) - 1000.0) / 1000.0;
      az  = (real'($urandom_range(0, 2000)) - 1000.0) / 1000.0;
      nrm = $sqrt(ax * ax + ay * ay + az * az);
      if (nrm < 0.01) begin
        ax  = 0.0;
        ay  = 0.0;
        az  = 1.0;
        nrm = 1.0;
      end
      u[0] = 16'(int'(ax / nrm * 16384.0));
      u[1] = 16'(int'(ay / nrm * 16384.0));
      u[2] = 16'(int'(az / nrm * 16384.0));
      u[3] = 16'(int'($cos(ang) * 16384.0));
      u[4] = 16'(int'($sin(ang) * 16384.0));
    end
    load_axis(o[0], o[1], o[2], u[0], u[1], u[2], u[3], u[4]);
  endtask

  // Random requests with gaps, broken up by stretches of back-to-back traffic.
  task automatic run_random(input int n);
    int burst_left;
    int g;
    burst_left = 0;
    for (int i = 0; i < n; i++) begin
      if (burst_left > 0) begin
        burst_left--;
      end else if ($urandom_range(0, 15) == 0) begin
        burst_left = $urandom_range(10, 60);
      end else begin
        g = gap_len();
        if (g > 0) idle(g);
      end
      send_vertex(rand_vertex());
    end
  endtask

  initial begin
    sb = new;
    sb.load_reset();
    rst     = 1'b1;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    start   = 1'b0;
    coord_x = '0;
    coord_y = '0;
    coord_z = '0;
    weight  = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset setting is the identity: every displacement must be zero,
    // even at the coordinate and weight extremes.
    send_vertex(vertex_t'{32'sh0, 32'sh0, 32'sh0, 16'sd16384});
    send_vertex(vertex_t'{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 16'sh7fff});
    send_vertex(vertex_t'{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 16'sh8000});

    // Quarter turn about +z with the origin at (1.5, -2, 0).
    load_axis(32'sh0001_8000, 32'shfffe_0000, 32'sh0, 16'sd0, 16'sd0, 16'sd16384,
              16'sd0, 16'sd16384);
    send_vertex(vertex_t'{32'sh0001_0000, 32'sh0, 32'sh0, 16'sd16384});
    send_vertex(vertex_t'{32'sh0, 32'sh0001_0000, 32'sh0005_0000, 16'sd16384});
    send_vertex(vertex_t'{32'sh0003_0000, 32'sh0002_0000, 32'sh0, 16'sd0});
    send_vertex(vertex_t'{32'sh0003_0000, 32'sh0002_0000, 32'sh0, 16'sh8000});
    send_vertex(vertex_t'{32'shfffd_4000, 32'sh0007_0000, 32'sh1, 16'sh7fff});
    // far from the axis: output clamps both ways
    send_vertex(vertex_t'{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh0, 16'sh7fff});
    send_vertex(vertex_t'{32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 16'sh8000});
    send_vertex(vertex_t'{32'shffff_ffff, 32'shffff_ffff, 32'shffff_ffff, 16'sd1});

    // Out-of-range patterns: non-unit axis at the 16-bit extremes,
    // cos = -2.0, origin at the coordinate extremes.
    load_axis(32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 16'sh8000, 16'sh7fff, 16'sh8000,
              16'sh8000, 16'sh7fff);
    send_vertex(vertex_t'{32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 16'sh7fff});
    send_vertex(vertex_t'{32'sh0, 32'sh0, 32'sh0, 16'sh8000});
    send_vertex(vertex_t'{32'sh8000_0000, 32'sh7fff_ffff, 32'sh0, 16'sd16384});
    send_vertex(vertex_t'{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 16'sd1});

    // Inconsistent cos/sin (both -1.0) with a non-unit axis.
    load_axis(32'sh7fff_ffff, 32'sh0, 32'sh8000_0000, 16'shc000, 16'sd16384, 16'sd0,
              16'shc000, 16'shc000);
    send_vertex(vertex_t'{32'sh7fff_0000, 32'sh0001_0000, 32'sh8000_0000, 16'sd16384});
    send_vertex(vertex_t'{32'sh0, 32'shffff_0000, 32'sh0, 16'shc000});
    send_vertex(vertex_t'{32'sh1234_5678, 32'shedcb_a987, 32'sh0f0f_0f0f, 16'sh5555});

    // Half turn about +x.
    load_axis(32'sh0, 32'sh0001_0000, 32'sh0, 16'sd16384, 16'sd0, 16'sd0,
              16'shc000, 16'sd0);
    send_vertex(vertex_t'{32'sh0002_0000, 32'sh0003_0000, 32'shfffc_0000, 16'sd16384});
    send_vertex(vertex_t'{32'sh0, 32'sh0, 32'sh0001_0000, 16'shaaaa});

    // Random phases, each under a fresh axis setting.
    for (int ph = 0; ph < 12; ph++) begin
      random_axis();
      run_random(160);
    end

    drain();
    if (sb.expected_disp.size() != 0) begin
      $error("%0d results never arrived", sb.expected_disp.size());
      sb.fails++;
    end
    if (sb.fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
